// File: rtl/core/gregorian_date_add_days_macros.svh
// Assertion macros used by the date adder's top-level RTL file.
`ifndef GREGORIAN_DATE_ADD_DAYS_MACROS_SVH
`define GREGORIAN_DATE_ADD_DAYS_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define GDA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("date adder: same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define GDA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("date adder: next-cycle check failed");

`endif

// File: rtl/core/gda_pkg.sv
// Shared types, constants and calendar helpers for the Gregorian date adder.
package gda_pkg;

  // Field widths of the input and result beats.
  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int DAYS_W   = 16;
  localparam int STATUS_W = 2;

  // Calendar limits.
  localparam logic [YEAR_W-1:0]  MAX_YEAR    = YEAR_W'(9999);
  localparam logic [YEAR_W-1:0]  LEAP_CYCLE  = YEAR_W'(400);
  localparam logic [MONTH_W-1:0] LAST_MONTH  = MONTH_W'(12);
  localparam logic [MONTH_W-1:0] FIRST_MONTH = MONTH_W'(1);
  localparam logic [DAY_W-1:0]   FIRST_DAY   = DAY_W'(1);

  // Status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_INVALID  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

  // Microcode operations.
  localparam int OP_W = 2;
  localparam logic [OP_W-1:0] OP_MOD   = 2'd0;
  localparam logic [OP_W-1:0] OP_CHECK = 2'd1;
  localparam logic [OP_W-1:0] OP_WALK  = 2'd2;
  localparam logic [OP_W-1:0] OP_FIN   = 2'd3;

  // Step addresses of the control store.
  localparam int PC_W = 2;
  localparam int UCODE_DEPTH = 4;
  localparam logic [PC_W-1:0] STEP_MOD   = 2'd0;
  localparam logic [PC_W-1:0] STEP_CHECK = 2'd1;
  localparam logic [PC_W-1:0] STEP_WALK  = 2'd2;
  localparam logic [PC_W-1:0] STEP_FIN   = 2'd3;

  // One control word: the operation and the target taken when its condition holds.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [PC_W-1:0] tgt;
  } gda_uword_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    logic            load;
    logic            step;
    logic [OP_W-1:0] op;
  } gda_ctrl_t;

  // Finished result as seen by the output register.
  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [STATUS_W-1:0] status;
  } gda_res_t;

  // Month length in days; zero for a month code outside January to December.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic is_leap);
    logic [DAY_W-1:0] len;
    begin
      case (m)
        4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
        4'd4, 4'd6, 4'd9, 4'd11:                     len = DAY_W'(30);
        4'd2:                                        len = is_leap ? DAY_W'(29) : DAY_W'(28);
        default:                                     len = '0;
      endcase
      return len;
    end
  endfunction

endpackage

// File: rtl/core/gda_sequencer.sv
// Step counter and control store that run the date adder's microprogram.
module gda_sequencer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                cond,
  input  logic                out_free,
  output gda_pkg::gda_ctrl_t  ctrl,
  output logic                busy,
  output logic                done
);
  import gda_pkg::*;

  // Microprogram: reduce the year modulo 400, check the date, walk months, finish.
  localparam gda_uword_t UCODE [UCODE_DEPTH] = '{
    '{op: OP_MOD,   tgt: STEP_MOD},
    '{op: OP_CHECK, tgt: STEP_FIN},
    '{op: OP_WALK,  tgt: STEP_WALK},
    '{op: OP_FIN,   tgt: STEP_MOD}
  };

  logic [PC_W-1:0] pc_r, pc_nxt;
  logic            busy_r, busy_nxt;
  gda_uword_t      uw;

  assign uw   = UCODE[pc_r];
  assign done = busy_r && (uw.op == OP_FIN) && out_free;
  assign busy = busy_r;

  assign ctrl.load = start;
  assign ctrl.step = busy_r;
  assign ctrl.op   = uw.op;

  // Next step: jump on the condition, otherwise fall through; the finish step waits for a free output.
  always_comb begin
    pc_nxt   = pc_r;
    busy_nxt = busy_r;
    if (start) begin
      pc_nxt   = STEP_MOD;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (uw.op == OP_FIN) begin
        if (out_free) begin
          busy_nxt = 1'b0;
        end
      end else if (cond) begin
        pc_nxt = uw.tgt;
      end else begin
        pc_nxt = pc_r + PC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= STEP_MOD;
      busy_r <= 1'b0;
    end else begin
      pc_r   <= pc_nxt;
      busy_r <= busy_nxt;
    end
  end

endmodule

// File: rtl/core/gda_datapath.sv
// Date registers, leap and month-length logic, and the month walk of the date adder.
module gda_datapath (
  input  logic                          clk,
  input  gda_pkg::gda_ctrl_t            ctrl,
  input  logic [gda_pkg::YEAR_W-1:0]    in_year,
  input  logic [gda_pkg::MONTH_W-1:0]   in_month,
  input  logic [gda_pkg::DAY_W-1:0]     in_day,
  input  logic [gda_pkg::DAYS_W-1:0]    in_days,
  output logic                          cond,
  output gda_pkg::gda_res_t             res
);
  import gda_pkg::*;

  logic [YEAR_W-1:0]  y_r, y_nxt;
  logic [YEAR_W-1:0]  rem_r, rem_nxt;
  logic [MONTH_W-1:0] m_r, m_nxt;
  logic [DAY_W-1:0]   d_r, d_nxt;
  logic [DAYS_W-1:0]  n_r, n_nxt;
  logic               bad_r, bad_nxt;

  logic               is_leap;
  logic [DAY_W-1:0]   len;
  logic [DAYS_W:0]    sum;
  logic               fits;
  logic               invalid;
  logic [DAY_W-1:0]   used;
  logic [YEAR_W-1:0]  rem_inc;

  // Leap test from the year modulo 400: divisible by 4, and not 100, 200 or 300.
  assign is_leap = (rem_r[1:0] == 2'b00) && (rem_r != YEAR_W'(100)) &&
                   (rem_r != YEAR_W'(200)) && (rem_r != YEAR_W'(300));
  assign len     = month_len(m_r, is_leap);
  assign sum     = {{(DAYS_W + 1 - DAY_W){1'b0}}, d_r} + {1'b0, n_r};
  assign fits    = sum <= {{(DAYS_W + 1 - DAY_W){1'b0}}, len};
  assign invalid = (y_r == '0) || (y_r > MAX_YEAR) || (m_r == '0) ||
                   (m_r > LAST_MONTH) || (d_r == '0) || (d_r > len);
  // Days consumed when leaving the current month.
  assign used    = len - d_r + DAY_W'(1);
  assign rem_inc = (rem_r == LEAP_CYCLE - YEAR_W'(1)) ? '0 : rem_r + YEAR_W'(1);

  // Branch condition for the sequencer.
  always_comb begin
    case (ctrl.op)
      OP_MOD:   cond = rem_r >= LEAP_CYCLE;
      OP_CHECK: cond = invalid;
      OP_WALK:  cond = !fits;
      default:  cond = 1'b0;
    endcase
  end

  // Register updates for each operation.
  always_comb begin
    y_nxt   = y_r;
    rem_nxt = rem_r;
    m_nxt   = m_r;
    d_nxt   = d_r;
    n_nxt   = n_r;
    bad_nxt = bad_r;
    if (ctrl.load) begin
      y_nxt   = in_year;
      rem_nxt = in_year;
      m_nxt   = in_month;
      d_nxt   = in_day;
      n_nxt   = in_days;
      bad_nxt = 1'b0;
    end else if (ctrl.step) begin
      case (ctrl.op)
        OP_MOD: begin
          if (rem_r >= LEAP_CYCLE) begin
            rem_nxt = rem_r - LEAP_CYCLE;
          end
        end
        OP_CHECK: begin
          bad_nxt = invalid;
        end
        OP_WALK: begin
          if (fits) begin
            d_nxt = sum[DAY_W-1:0];
            n_nxt = '0;
          end else begin
            n_nxt = n_r - {{(DAYS_W - DAY_W){1'b0}}, used};
            d_nxt = FIRST_DAY;
            if (m_r == LAST_MONTH) begin
              m_nxt   = FIRST_MONTH;
              y_nxt   = y_r + YEAR_W'(1);
              rem_nxt = rem_inc;
            end else begin
              m_nxt = m_r + MONTH_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    y_r   <= y_nxt;
    rem_r <= rem_nxt;
    m_r   <= m_nxt;
    d_r   <= d_nxt;
    n_r   <= n_nxt;
    bad_r <= bad_nxt;
  end

  // Final result; the date fields are zero whenever the status is not OK.
  always_comb begin
    res = '0;
    if (bad_r) begin
      res.status = STATUS_INVALID;
    end else if (y_r > MAX_YEAR) begin
      res.status = STATUS_OVERFLOW;
    end else begin
      res.status = STATUS_OK;
      res.year   = y_r;
      res.month  = m_r;
      res.day    = d_r;
    end
  end

endmodule

// File: rtl/core/gregorian_date_add_days.sv
// Top level of the Gregorian date adder: sequencer, datapath and output register.
//
//   Channel  Direction  Handshake            Beat contents
//   in_      input      in_valid / in_stall  start_year, start_month, start_day, days_to_add
//   out_     output     out_valid / out_stall result_year, result_month, result_day, status
//
// An item reduces the year modulo 400 by repeated subtraction (at most 40 times, for the
// largest year code), checks the date, then walks month by month until the days fit
// (about 2155 months for 65535 days). An invalid start date skips the walk.
// Reset clears the sequencer and the output valid flag; no clearing pass is needed.
// A finished result waits in the output register while out_stall is high, and the next
// item can be taken during that wait; its last step holds until the register is free.
`include "gregorian_date_add_days_macros.svh"
module gregorian_date_add_days (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [gda_pkg::YEAR_W-1:0]      in_start_year,
  input  logic [gda_pkg::MONTH_W-1:0]     in_start_month,
  input  logic [gda_pkg::DAY_W-1:0]       in_start_day,
  input  logic [gda_pkg::DAYS_W-1:0]      in_days_to_add,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [gda_pkg::YEAR_W-1:0]      out_result_year,
  output logic [gda_pkg::MONTH_W-1:0]     out_result_month,
  output logic [gda_pkg::DAY_W-1:0]       out_result_day,
  output logic [gda_pkg::STATUS_W-1:0]    out_status
);
  import gda_pkg::*;

  gda_ctrl_t ctrl;
  gda_res_t  res;
  gda_res_t  res_r;
  logic      cond;
  logic      busy;
  logic      done;
  logic      start;
  logic      out_free;
  logic      out_valid_r, out_valid_nxt;

  // A new beat is taken whenever the sequencer is idle.
  assign in_stall = busy;
  assign start    = in_valid && !busy;
  assign out_free = !out_valid_r || !out_stall;

  gda_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .cond     (cond),
    .out_free (out_free),
    .ctrl     (ctrl),
    .busy     (busy),
    .done     (done)
  );

  gda_datapath u_dp (
    .clk      (clk),
    .ctrl     (ctrl),
    .in_year  (in_start_year),
    .in_month (in_start_month),
    .in_day   (in_start_day),
    .in_days  (in_days_to_add),
    .cond     (cond),
    .res      (res)
  );

  // Output register: loaded at the last step, emptied when the beat is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (done) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_year  = res_r.year;
  assign out_result_month = res_r.month;
  assign out_result_day   = res_r.day;
  assign out_status       = res_r.status;

  // An error result carries an all-zero date.
  `GDA_ASSERT_NOW(a_err_zero, out_valid_r && (res_r.status != STATUS_OK),
                  (res_r.year == '0) && (res_r.month == '0) && (res_r.day == '0))

  // A good result is a plausible date within four-digit years.
  `GDA_ASSERT_NOW(a_ok_range, out_valid_r && (res_r.status == STATUS_OK),
                  (res_r.year != '0) && (res_r.year <= MAX_YEAR) &&
                  (res_r.month >= FIRST_MONTH) && (res_r.month <= LAST_MONTH) &&
                  (res_r.day != '0))

  // An accepted beat starts the microprogram.
  `GDA_ASSERT_NEXT(a_start_busy, in_valid && !in_stall, busy)

  // The last step always leaves a result waiting at the output.
  `GDA_ASSERT_NEXT(a_done_valid, done, out_valid_r)

endmodule

// File: dv/gregorian_date_add_days_tb.sv
// Self-checking testbench for the Gregorian date adder, with its own date predictor.
`timescale 1ns / 100ps

module gregorian_date_add_days_tb;

  // Run limits: the cycle limit is several times the worst case for every item at full size
  // plus every stall.
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_ITEMS = 240;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [gda_pkg::YEAR_W-1:0] in_start_year = '0;
  logic [gda_pkg::MONTH_W-1:0] in_start_month = '0;
  logic [gda_pkg::DAY_W-1:0] in_start_day = '0;
  logic [gda_pkg::DAYS_W-1:0] in_days_to_add = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [gda_pkg::YEAR_W-1:0] out_result_year;
  logic [gda_pkg::MONTH_W-1:0] out_result_month;
  logic [gda_pkg::DAY_W-1:0] out_result_day;
  logic [gda_pkg::STATUS_W-1:0] out_status;

  // Dates still owed by the block, oldest first.
  gda_pkg::gda_res_t pending_dates[$];
  gda_pkg::gda_res_t oldest_date;

  int mismatch_count = 0;
  int checked_count = 0;
  int invalid_seen = 0;
  int overflow_seen = 0;
  bit idle_on = 1'b1;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;

  gregorian_date_add_days uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_start_year    (in_start_year),
    .in_start_month   (in_start_month),
    .in_start_day     (in_start_day),
    .in_days_to_add   (in_days_to_add),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_year  (out_result_year),
    .out_result_month (out_result_month),
    .out_result_day   (out_result_day),
    .out_status       (out_status)
  );

  // Free-running clock with a 2 ns period.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Length of a month in days; zero for a month code outside January to December.
  function automatic int month_days(int y, int m);
    bit leap_yr;
    leap_yr = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    case (m)
      2: return leap_yr ? 29 : 28;
      4, 6, 9, 11: return 30;
      1, 3, 5, 7, 8, 10, 12: return 31;
      default: return 0;
    endcase
  endfunction

  // Date that lies the given number of days after the start date, with its status.
  function automatic gda_pkg::gda_res_t predict_later_date(
    input logic [gda_pkg::YEAR_W-1:0] y_in,
    input logic [gda_pkg::MONTH_W-1:0] m_in,
    input logic [gda_pkg::DAY_W-1:0] d_in,
    input logic [gda_pkg::DAYS_W-1:0] n_in
  );
    int y;
    int m;
    int d;
    int n;
    int len;
    gda_pkg::gda_res_t r;
    y = int'(y_in);
    m = int'(m_in);
    d = int'(d_in);
    n = int'(n_in);
    r.status = gda_pkg::STATUS_OK;
    if (y < 1 || y > int'(gda_pkg::MAX_YEAR) || m < 1 || m > 12 || d < 1
        || d > month_days(y, m)) begin
      r.status = gda_pkg::STATUS_INVALID;
    end else begin
      // Walk forward one month at a time until the remaining days fit.
      while (n > 0) begin
        len = month_days(y, m);
        if (d + n <= len) begin
          d = d + n;
          n = 0;
        end else begin
          n = n - (len - d + 1);
          d = 1;
          m = m + 1;
          if (m > 12) begin
            m = 1;
            y = y + 1;
          end
        end
      end
      if (y > int'(gda_pkg::MAX_YEAR)) begin
        r.status = gda_pkg::STATUS_OVERFLOW;
      end
    end
    // Any error status clears the date fields.
    if (r.status != gda_pkg::STATUS_OK) begin
      y = 0;
      m = 0;
      d = 0;
    end
    r.year = y[gda_pkg::YEAR_W-1:0];
    r.month = m[gda_pkg::MONTH_W-1:0];
    r.day = d[gda_pkg::DAY_W-1:0];
    return r;
  endfunction

  // Offers one start date and returns once the block has taken the beat.
  task automatic send_date(input int y, input int m, input int d, input int n);
    logic [gda_pkg::YEAR_W-1:0] yy;
    logic [gda_pkg::MONTH_W-1:0] mm;
    logic [gda_pkg::DAY_W-1:0] dd;
    logic [gda_pkg::DAYS_W-1:0] nn;
    yy = y[gda_pkg::YEAR_W-1:0];
    mm = m[gda_pkg::MONTH_W-1:0];
    dd = d[gda_pkg::DAY_W-1:0];
    nn = n[gda_pkg::DAYS_W-1:0];
    // Random gaps on the sender side before the beat is offered.
    while (idle_on && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_start_year <= yy;
    in_start_month <= mm;
    in_start_day <= dd;
    in_days_to_add <= nn;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    pending_dates.push_back(predict_later_date(yy, mm, dd, nn));
  endtask

  // Dates with nothing to add come back unchanged.
  task automatic test_zero_days();
    send_date(2024, 2, 29, 0);
    send_date(1, 1, 1, 0);
    send_date(9999, 12, 31, 0);
  endtask

  // Start dates that must be rejected, including every out-of-range field.
  task automatic test_invalid_dates();
    send_date(0, 1, 1, 5);
    send_date(10000, 1, 1, 0);
    send_date(16383, 15, 31, 65535);
    send_date(2023, 0, 10, 1);
    send_date(2023, 13, 1, 1);
    send_date(2023, 5, 0, 1);
    send_date(2023, 4, 31, 1);
    send_date(1900, 2, 29, 1);
    send_date(2024, 2, 30, 1);
  endtask

  // Month, year and leap-day boundaries, the largest day count and the overflow edge.
  task automatic test_calendar_edges();
    send_date(2023, 12, 31, 1);
    send_date(1900, 2, 28, 1);
    send_date(2000, 2, 28, 1);
    send_date(2100, 2, 28, 1);
    send_date(2000, 2, 29, 365);
    send_date(1, 1, 1, 65535);
    send_date(9820, 1, 1, 65535);
    send_date(9999, 1, 31, 334);
    send_date(9999, 1, 31, 335);
    send_date(9999, 12, 31, 1);
    send_date(9999, 12, 31, 65535);
  endtask

  // The receiver holds off for a long stretch while dates keep coming.
  task automatic test_output_backpressure();
    int y;
    int m;
    hold_requests <= hold_requests + 1;
    repeat (8) begin
      y = $urandom_range(1, 9999);
      m = $urandom_range(1, 12);
      send_date(y, m, $urandom_range(1, month_days(y, m)), $urandom_range(0, 60));
    end
  endtask

  // Mostly well-formed dates with short walks, some long ones, some near the last year,
  // and raw field noise; a middle stretch runs with no idling on either side.
  task automatic test_random_dates(input int count);
    int y;
    int m;
    int d;
    int n;
    int pick;
    for (int i = 0; i < count; i++) begin
      if (i == count / 3) begin
        idle_on = 1'b0;
      end
      if (i == count / 2) begin
        idle_on = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 15) begin
        y = $urandom_range(0, 16383);
        m = $urandom_range(0, 15);
        d = $urandom_range(0, 31);
      end else begin
        y = (pick < 25) ? $urandom_range(9800, 9999) : $urandom_range(1, 9999);
        m = $urandom_range(1, 12);
        d = $urandom_range(1, month_days(y, m));
      end
      pick = $urandom_range(99);
      if (pick < 80) begin
        n = $urandom_range(0, 800);
      end else if (pick < 92) begin
        n = $urandom_range(0, 4000);
      end else begin
        n = $urandom_range(0, 65535);
      end
      send_date(y, m, d, n);
    end
  endtask

  // Receiver side: random stalls, plus a long hold-off whenever one is requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_requests != holds_served) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      holds_served <= holds_served + 1;
    end else begin
      out_stall <= idle_on && ($urandom_range(99) < 7);
    end
  end

  // Reports one field that differs from the predicted date.
  function automatic void check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
      mismatch_count++;
    end
  endfunction

  // Each result beat is compared with the oldest predicted date.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_dates.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, actual %0d-%0d-%0d status %0d",
                 $time, out_result_year, out_result_month, out_result_day, out_status);
        mismatch_count++;
      end else begin
        oldest_date = pending_dates.pop_front();
        check_field("year", int'(oldest_date.year), int'(out_result_year));
        check_field("month", int'(oldest_date.month), int'(out_result_month));
        check_field("day", int'(oldest_date.day), int'(out_result_day));
        check_field("status", int'(oldest_date.status), int'(out_status));
        checked_count++;
        if (oldest_date.status == gda_pkg::STATUS_INVALID) begin
          invalid_seen++;
        end
        if (oldest_date.status == gda_pkg::STATUS_OVERFLOW) begin
          overflow_seen++;
        end
      end
    end
  end

  // Watchdog: a hung block ends the run as a failure.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("%0t: run exceeded the cycle limit with %0d dates outstanding",
             $time, pending_dates.size());
    $display("FAIL");
    $finish;
  end

  // Test sequence.
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_zero_days();
    test_invalid_dates();
    test_calendar_edges();
    test_output_backpressure();
    test_random_dates(RANDOM_ITEMS);
    in_valid <= 1'b0;
    // Drain the block, then give any stray beat time to show up.
    while (pending_dates.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Checked %0d result dates: %0d rejected start dates, %0d past the last year.",
             checked_count, invalid_seen, overflow_seen);
    $display("Covered leap and century boundaries, field extremes and a long output hold-off.");
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/gda_pkg.sv
rtl/core/gda_sequencer.sv
rtl/core/gda_datapath.sv
rtl/core/gregorian_date_add_days.sv
dv/gregorian_date_add_days_tb.sv
